// ===== src/sha1_pkg.sv =====
// shared constants and types for the sha-1 message hasher
package sha1_pkg;

  localparam logic [31:0] H0 = 32'h67452301;
  localparam logic [31:0] H1 = 32'hEFCDAB89;
  localparam logic [31:0] H2 = 32'h98BADCFE;
  localparam logic [31:0] H3 = 32'h10325476;
  localparam logic [31:0] H4 = 32'hC3D2E1F0;

  localparam logic [31:0] K0 = 32'h5A827999;
  localparam logic [31:0] K1 = 32'h6ED9EBA1;
  localparam logic [31:0] K2 = 32'h8F1BBCDC;
  localparam logic [31:0] K3 = 32'hCA62C1D6;

  localparam logic [7:0] PAD_MARK = 8'h80;

  localparam int SCHED_WORDS = 16;
  localparam int ROUNDS      = 80;
  localparam int RND_W       = 7;

  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    logic [31:0] d;
    logic [31:0] e;
  } wvars_t;

  typedef struct packed {
    logic       push;
    logic [7:0] byte_val;
    logic       step;
    logic       expand;
  } sched_ctl_t;

  localparam wvars_t CHAIN_INIT = '{a: H0, b: H1, c: H2, d: H3, e: H4};

endpackage

// ===== src/sha1_round.sv =====
// one sha-1 compression round, the shared arithmetic unit
module sha1_round (
  input  sha1_pkg::wvars_t          wv_i,
  input  logic [sha1_pkg::RND_W-1:0] rnd,
  input  logic [31:0]               w,
  output sha1_pkg::wvars_t          wv_o
);

  localparam int RW = sha1_pkg::RND_W;

  logic [31:0] f;
  logic [31:0] k;
  logic [31:0] t;

  always_comb begin
    if (rnd < RW'(20)) begin
      f = (wv_i.b & wv_i.c) | (~wv_i.b & wv_i.d);
      k = sha1_pkg::K0;
    end else if (rnd < RW'(40)) begin
      f = wv_i.b ^ wv_i.c ^ wv_i.d;
      k = sha1_pkg::K1;
    end else if (rnd < RW'(60)) begin
      f = (wv_i.b & wv_i.c) | (wv_i.b & wv_i.d) | (wv_i.c & wv_i.d);
      k = sha1_pkg::K2;
    end else begin
      f = wv_i.b ^ wv_i.c ^ wv_i.d;
      k = sha1_pkg::K3;
    end
    t = {wv_i.a[26:0], wv_i.a[31:27]} + f + wv_i.e + k + w;
    wv_o.a = t;
    wv_o.b = wv_i.a;
    wv_o.c = {wv_i.b[1:0], wv_i.b[31:2]};
    wv_o.d = wv_i.c;
    wv_o.e = wv_i.d;
  end

endmodule

// ===== src/sha1_sched.sv =====
// block buffer and rolling 16-word message schedule
module sha1_sched (
  input  logic                 clk,
  input  sha1_pkg::sched_ctl_t ctl,
  output logic [31:0]          w_cur
);

  localparam int N = sha1_pkg::SCHED_WORDS;

  logic [31:0] win_r   [N];
  logic [31:0] win_nxt [N];
  logic [31:0] mix;

  always_comb begin
    mix   = win_r[13] ^ win_r[8] ^ win_r[2] ^ win_r[0];
    w_cur = ctl.expand ? {mix[30:0], mix[31]} : win_r[0];
  end

  always_comb begin
    win_nxt = win_r;
    if (ctl.push) begin
      for (int k = 0; k < N - 1; k++) begin
        win_nxt[k] = {win_r[k][23:0], win_r[k+1][31:24]};
      end
      win_nxt[N-1] = {win_r[N-1][23:0], ctl.byte_val};
    end else if (ctl.step) begin
      for (int k = 0; k < N - 1; k++) begin
        win_nxt[k] = win_r[k+1];
      end
      win_nxt[N-1] = w_cur;
    end
  end

  always_ff @(posedge clk) begin
    win_r <= win_nxt;
  end

endmodule

// ===== src/sha1_message_hasher.sv =====
// sha-1 message hasher top level: sequencer, chaining words, padding and digest output
// Takes at most one message byte per input transaction and returns the SHA-1 digest as
// five output transactions (word 0 most significant) after an end_of_message transaction,
// then starts the next message from the standard initial values. A transaction that
// completes a 64-byte block starts a compression: the single round adder runs the 80
// rounds one per cycle, then S_FOLD adds the result into the chaining words. Padding
// pushes its bytes (0x80, zero fill, a step to switch to the length, 8 length bytes) one
// per cycle through the same block buffer, pausing while a full block is compressed, so
// closing a message takes the padding plus one or two block compressions, then one digest
// word per cycle while out_ready is high. in_ready is low from the transaction that fills
// a block or ends a message until the compression, or the last digest word, is done.
module sha1_message_hasher (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_has_byte,
  input  logic        in_end_of_message,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_digest_word,
  output logic [2:0]  out_word_index,
  output logic        out_last_word
);

  localparam int RW = sha1_pkg::RND_W;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_ROUND = 3'd1;
  localparam logic [2:0] S_FOLD  = 3'd2;
  localparam logic [2:0] S_PAD   = 3'd3;
  localparam logic [2:0] S_OUT   = 3'd4;

  localparam logic [1:0] PH_MARK = 2'd0;
  localparam logic [1:0] PH_ZERO = 2'd1;
  localparam logic [1:0] PH_LEN  = 2'd2;

  localparam logic [5:0] LEN_FILL  = 6'd56;
  localparam logic [2:0] LAST_WORD = 3'd4;

  logic [2:0]       state_r,   state_nxt;
  logic [RW-1:0]    rnd_r,     rnd_nxt;
  logic [5:0]       fill_r,    fill_nxt;
  logic [60:0]      count_r,   count_nxt;
  logic [63:0]      len_r,     len_nxt;
  logic [2:0]       len_cnt_r, len_cnt_nxt;
  logic [1:0]       phase_r,   phase_nxt;
  logic             pad_r,     pad_nxt;
  logic             done_r,    done_nxt;
  logic [2:0]       idx_r,     idx_nxt;
  sha1_pkg::wvars_t chain_r,   chain_nxt;
  sha1_pkg::wvars_t wv_r,      wv_nxt;

  logic             push;
  logic [7:0]       push_val;
  logic             push_wrap;
  logic             step;
  logic [31:0]      w_cur;
  sha1_pkg::wvars_t wv_round;
  sha1_pkg::sched_ctl_t sched_ctl;

  assign in_ready        = (state_r == S_IDLE);
  assign out_valid       = (state_r == S_OUT);
  assign out_digest_word = chain_r.a;
  assign out_word_index  = idx_r;
  assign out_last_word   = (idx_r == LAST_WORD);

  assign push_wrap = push && (fill_r == 6'd63);

  always_comb begin
    sched_ctl.push     = push;
    sched_ctl.byte_val = push_val;
    sched_ctl.step     = step;
    sched_ctl.expand   = (rnd_r >= RW'(sha1_pkg::SCHED_WORDS));
  end

  sha1_sched u_sched (
    .clk   (clk),
    .ctl   (sched_ctl),
    .w_cur (w_cur)
  );

  sha1_round u_round (
    .wv_i (wv_r),
    .rnd  (rnd_r),
    .w    (w_cur),
    .wv_o (wv_round)
  );

  always_comb begin
    state_nxt   = state_r;
    rnd_nxt     = rnd_r;
    fill_nxt    = fill_r;
    count_nxt   = count_r;
    len_nxt     = len_r;
    len_cnt_nxt = len_cnt_r;
    phase_nxt   = phase_r;
    pad_nxt     = pad_r;
    done_nxt    = done_r;
    idx_nxt     = idx_r;
    chain_nxt   = chain_r;
    wv_nxt      = wv_r;
    push        = 1'b0;
    push_val    = 8'h00;
    step        = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (in_has_byte) begin
            push      = 1'b1;
            push_val  = in_data_byte;
            count_nxt = count_r + 61'd1;
          end
          if (in_end_of_message) begin
            pad_nxt     = 1'b1;
            phase_nxt   = PH_MARK;
            len_cnt_nxt = 3'd0;
            len_nxt     = {count_nxt, 3'b000};
            state_nxt   = S_PAD;
          end
        end
      end
      S_PAD: begin
        case (phase_r)
          PH_MARK: begin
            push      = 1'b1;
            push_val  = sha1_pkg::PAD_MARK;
            phase_nxt = PH_ZERO;
          end
          PH_ZERO: begin
            if (fill_r == LEN_FILL) begin
              phase_nxt = PH_LEN;
            end else begin
              push = 1'b1;
            end
          end
          PH_LEN: begin
            push        = 1'b1;
            push_val    = len_r[63:56];
            len_nxt     = {len_r[55:0], 8'h00};
            len_cnt_nxt = len_cnt_r + 3'd1;
            if (len_cnt_r == 3'd7) begin
              done_nxt = 1'b1;
            end
          end
          default: begin
            phase_nxt = PH_MARK;
          end
        endcase
      end
      S_ROUND: begin
        step    = 1'b1;
        wv_nxt  = wv_round;
        rnd_nxt = rnd_r + RW'(1);
        if (rnd_r == RW'(sha1_pkg::ROUNDS - 1)) begin
          state_nxt = S_FOLD;
        end
      end
      S_FOLD: begin
        chain_nxt.a = chain_r.a + wv_r.a;
        chain_nxt.b = chain_r.b + wv_r.b;
        chain_nxt.c = chain_r.c + wv_r.c;
        chain_nxt.d = chain_r.d + wv_r.d;
        chain_nxt.e = chain_r.e + wv_r.e;
        if (done_r) begin
          state_nxt = S_OUT;
        end else if (pad_r) begin
          state_nxt = S_PAD;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_OUT: begin
        if (out_ready) begin
          chain_nxt = '{a: chain_r.b, b: chain_r.c, c: chain_r.d, d: chain_r.e, e: chain_r.a};
          idx_nxt   = idx_r + 3'd1;
          if (idx_r == LAST_WORD) begin
            chain_nxt = sha1_pkg::CHAIN_INIT;
            idx_nxt   = 3'd0;
            count_nxt = '0;
            pad_nxt   = 1'b0;
            done_nxt  = 1'b0;
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (push) begin
      fill_nxt = fill_r + 6'd1;
    end
    if (push_wrap) begin
      rnd_nxt   = '0;
      wv_nxt    = chain_r;
      state_nxt = S_ROUND;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      rnd_r     <= '0;
      fill_r    <= '0;
      count_r   <= '0;
      len_cnt_r <= '0;
      phase_r   <= PH_MARK;
      pad_r     <= 1'b0;
      done_r    <= 1'b0;
      idx_r     <= '0;
      chain_r   <= sha1_pkg::CHAIN_INIT;
    end else begin
      state_r   <= state_nxt;
      rnd_r     <= rnd_nxt;
      fill_r    <= fill_nxt;
      count_r   <= count_nxt;
      len_cnt_r <= len_cnt_nxt;
      phase_r   <= phase_nxt;
      pad_r     <= pad_nxt;
      done_r    <= done_nxt;
      idx_r     <= idx_nxt;
      chain_r   <= chain_nxt;
    end
  end

  always_ff @(posedge clk) begin
    len_r <= len_nxt;
    wv_r  <= wv_nxt;
  end

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("input and output sides active together");

  a_round_end: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ROUND && rnd_r == RW'(sha1_pkg::ROUNDS - 1)) |=> (state_r == S_FOLD))
    else $error("compression did not end after the last round");

  a_digest_aligned: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (fill_r == 6'd0 && out_word_index <= LAST_WORD))
    else $error("digest output with a partly filled block or bad index");

  a_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && out_last_word) |=>
      (in_ready && count_r == 61'd0 && chain_r == sha1_pkg::CHAIN_INIT))
    else $error("hasher did not restart after the last digest word");

endmodule

// ===== dv/tb_sha1_message_hasher.sv =====
// self-checking testbench for sha1_message_hasher: byte stream in, digest words checked
module tb_sha1_message_hasher;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT = 600_000;
  localparam int          RANDOM_ITEMS = 260;
  localparam int          DRAIN_CYCLES = 200;

  typedef struct {
    logic [31:0] word;
    logic [2:0]  index;
    logic        last;
  } digest_word_t;

  class sha1_digest_scoreboard;
    logic [31:0]  chain[5];
    logic [7:0]   blk[64];
    logic [5:0]   fill;
    logic [60:0]  nbytes;
    digest_word_t pending[$];
    int           mismatches;
    int           words_checked;

    function new();
      mismatches    = 0;
      words_checked = 0;
      restart();
    endfunction

    function void restart();
      chain[0] = sha1_pkg::H0;
      chain[1] = sha1_pkg::H1;
      chain[2] = sha1_pkg::H2;
      chain[3] = sha1_pkg::H3;
      chain[4] = sha1_pkg::H4;
      fill     = '0;
      nbytes   = '0;
    endfunction

    function void compress_block();
      logic [31:0] w[16];
      logic [31:0] a, b, c, d, e, f, k, t, x;
      int          slot;
      for (int i = 0; i < 16; i++) begin
        w[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
      end
      a = chain[0];
      b = chain[1];
      c = chain[2];
      d = chain[3];
      e = chain[4];
      for (int r = 0; r < 80; r++) begin
        slot = r & 15;
        if (r >= 16) begin
          x = w[(r - 3) & 15] ^ w[(r - 8) & 15] ^ w[(r - 14) & 15] ^ w[slot];
          w[slot] = {x[30:0], x[31]};
        end
        if (r < 20) begin
          f = (b & c) | (~b & d);
          k = sha1_pkg::K0;
        end else if (r < 40) begin
          f = b ^ c ^ d;
          k = sha1_pkg::K1;
        end else if (r < 60) begin
          f = (b & c) | (b & d) | (c & d);
          k = sha1_pkg::K2;
        end else begin
          f = b ^ c ^ d;
          k = sha1_pkg::K3;
        end
        t = {a[26:0], a[31:27]} + f + e + k + w[slot];
        e = d;
        d = c;
        c = {b[1:0], b[31:2]};
        b = a;
        a = t;
      end
      chain[0] += a;
      chain[1] += b;
      chain[2] += c;
      chain[3] += d;
      chain[4] += e;
    endfunction

    function void push_byte(logic [7:0] v);
      blk[fill] = v;
      fill      = fill + 6'd1;
      if (fill == 6'd0) compress_block();
    endfunction

    function void note_input(logic [7:0] data, logic has, logic eom);
      logic [63:0] bit_len;
      if (has) begin
        push_byte(data);
        nbytes = nbytes + 61'd1;
      end
      if (!eom) return;
      bit_len = {nbytes, 3'b000};
      push_byte(sha1_pkg::PAD_MARK);
      while (fill != 6'd56) push_byte(8'h00);
      for (int i = 0; i < 8; i++) push_byte(bit_len[63 - 8*i -: 8]);
      for (int i = 0; i < 5; i++) begin
        pending.push_back('{word: chain[i], index: 3'(i), last: (i == 4)});
      end
      restart();
    endfunction

    function void check_result(logic [31:0] word, logic [2:0] index, logic last);
      digest_word_t want;
      words_checked++;
      if (pending.size() == 0) begin
        $error("unexpected digest transaction: digest_word %h word_index %0d", word, index);
        mismatches++;
        return;
      end
      want = pending.pop_front();
      if (word !== want.word) begin
        $error("digest_word mismatch: expected %h, actual %h", want.word, word);
        mismatches++;
      end
      if (index !== want.index) begin
        $error("word_index mismatch: expected %0d, actual %0d", want.index, index);
        mismatches++;
      end
      if (last !== want.last) begin
        $error("last_word mismatch: expected %0b, actual %0b", want.last, last);
        mismatches++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_data_byte = 8'h00;
  logic        in_has_byte = 1'b0;
  logic        in_end_of_message = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] out_digest_word;
  logic [2:0]  out_word_index;
  logic        out_last_word;

  int unsigned cycle_count = 0;
  int          byte_items = 0;
  int          idle_items = 0;
  int          messages = 0;
  int          live_items = 0;
  bit          in_burst = 1'b0;
  bit          out_burst = 1'b0;

  sha1_digest_scoreboard sb = new();

  sha1_message_hasher i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_data_byte      (in_data_byte),
    .in_has_byte       (in_has_byte),
    .in_end_of_message (in_end_of_message),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_digest_word   (out_digest_word),
    .out_word_index    (out_word_index),
    .out_last_word     (out_last_word)
  );

  always #5 clk = ~clk;

  always_ff @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  task automatic send_item(logic [7:0] data, logic has, logic eom);
    int gap;
    if ($urandom_range(0, 15) == 0) in_burst = ~in_burst;
    gap = in_burst ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid          <= 1'b1;
    in_data_byte      <= data;
    in_has_byte       <= has;
    in_end_of_message <= eom;
    do @(posedge clk); while (in_ready !== 1'b1);
    sb.note_input(data, has, eom);
    if (has) byte_items++;
    if (eom) messages++;
    if (has || eom) live_items++;
    else idle_items++;
  endtask

  task automatic send_message(int len, bit close_on_byte);
    for (int n = 0; n < len; n++) begin
      if ($urandom_range(0, 9) == 0) send_item(8'($urandom), 1'b0, 1'b0);
      send_item(8'($urandom), 1'b1, close_on_byte && (n == len - 1));
    end
    if (!close_on_byte || len == 0) send_item(8'($urandom), 1'b0, 1'b1);
  endtask

  // result side: random back-pressure, every accepted transaction goes to the scoreboard
  initial begin
    int stall;
    wait (rst_n === 1'b1);
    forever begin
      if ($urandom_range(0, 15) == 0) out_burst = ~out_burst;
      stall = out_burst ? 0 : $urandom_range(0, 14);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (out_valid !== 1'b1);
      sb.check_result(out_digest_word, out_word_index, out_last_word);
    end
  end

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("timeout after %0d cycles", cycle_count);
    $display("sha1_message_hasher verification failed");
    $finish;
  end

  initial begin
    int          draw;
    int          len;
    logic [7:0]  boundary_len[4];
    boundary_len = '{8'd55, 8'd56, 8'd63, 8'd64};

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty message, idle transaction, "abc", single bytes, close without a byte
    send_item(8'h00, 1'b0, 1'b1);
    send_item(8'hFF, 1'b0, 1'b0);
    send_item(8'h61, 1'b1, 1'b0);
    send_item(8'h62, 1'b1, 1'b0);
    send_item(8'h63, 1'b1, 1'b1);
    send_item(8'hFF, 1'b1, 1'b1);
    send_item(8'h00, 1'b1, 1'b0);
    send_item(8'hA5, 1'b0, 1'b1);
    send_item(8'h5A, 1'b0, 1'b0);
    send_item(8'hFF, 1'b0, 1'b1);
    send_item(8'h80, 1'b1, 1'b0);
    send_item(8'h7F, 1'b1, 1'b1);

    // padding spills into a second block, then a message of exactly one block
    send_message(56, 1'b1);
    send_message(64, 1'b0);

    while (live_items < RANDOM_ITEMS) begin
      draw = $urandom_range(0, 19);
      if (draw < 13) len = $urandom_range(0, 9);
      else if (draw < 17) len = boundary_len[$urandom_range(0, 3)];
      else len = $urandom_range(10, 70);
      send_message(len, $urandom_range(0, 1));
    end
    in_valid <= 1'b0;

    while (sb.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d messages hashed from %0d byte transactions plus %0d idle transactions",
             messages, byte_items, idle_items);
    $display("%0d digest words compared, %0d mismatches", sb.words_checked, sb.mismatches);
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("sha1_message_hasher verification clean");
    end else begin
      $display("sha1_message_hasher verification failed");
    end
    $finish;
  end

endmodule
